### rtl/dfw_pkg.sv
// ---------------------------------------------------------------------------
// dfw_pkg
// Shared types, constants and the control store of the depth-first walker.
// ---------------------------------------------------------------------------
package dfw_pkg;

  localparam int NODE_CNT = 64;
  localparam int NODE_W   = $clog2(NODE_CNT);
  localparam int CAND_W   = NODE_W + 1;
  localparam int STEP_W   = 5;

  typedef logic [STEP_W-1:0] step_t;

  // request codes
  localparam logic [1:0] REQ_ADD_NODE = 2'd0;
  localparam logic [1:0] REQ_ADD_EDGE = 2'd1;
  localparam logic [1:0] REQ_WALK     = 2'd2;
  localparam logic [1:0] REQ_CLEAR    = 2'd3;

  // control store addresses
  localparam step_t S_IDLE    = step_t'(0);
  localparam step_t S_DISP_N  = step_t'(1);
  localparam step_t S_DISP_E  = step_t'(2);
  localparam step_t S_DISP_C  = step_t'(3);
  localparam step_t S_WALK    = step_t'(4);
  localparam step_t S_VISIT   = step_t'(5);
  localparam step_t S_LOAD    = step_t'(6);
  localparam step_t S_SCAN    = step_t'(7);
  localparam step_t S_TEST    = step_t'(8);
  localparam step_t S_POP     = step_t'(9);
  localparam step_t S_POPLD   = step_t'(10);
  localparam step_t S_PUSH    = step_t'(11);
  localparam step_t S_FINISH  = step_t'(12);
  localparam step_t S_MISS    = step_t'(13);
  localparam step_t S_ADDN    = step_t'(14);
  localparam step_t S_EDGE_RD = step_t'(15);
  localparam step_t S_EDGE_WR = step_t'(16);
  localparam step_t S_CLR     = step_t'(17);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WALK_INIT,
    OP_VISIT_START,
    OP_LOAD_ROW,
    OP_SCAN,
    OP_POP,
    OP_POP_LOAD,
    OP_PUSH,
    OP_EMIT_LAST,
    OP_EMIT_MISS,
    OP_SET_PRESENT,
    OP_EDGE_READ,
    OP_EDGE_WRITE,
    OP_CLEAR
  } dfw_op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_START,
    C_REQ_NODE,
    C_REQ_EDGE,
    C_REQ_CLEAR,
    C_START_BAD,
    C_SCAN_MORE,
    C_HIT,
    C_LAST_FRAME
  } dfw_cond_t;

  typedef struct packed {
    dfw_op_t   op;
    dfw_cond_t cond;
    step_t     target;
  } dfw_ctrl_t;

  typedef struct packed {
    logic req_node;
    logic req_edge;
    logic req_clear;
    logic start_bad;
    logic scan_more;
    logic hit;
    logic last_frame;
  } dfw_flags_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] neighbor_id;
  } dfw_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] visited_node;
    logic              is_last;
    logic              start_missing;
  } dfw_out_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [CAND_W-1:0] next;
  } dfw_frame_t;

  // control store: op, jump condition, jump target
  function automatic dfw_ctrl_t ucode_rom(input step_t step);
    dfw_ctrl_t cw;
    cw = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    unique case (step)
      S_IDLE:    cw = '{op: OP_NOP,         cond: C_NOT_START,  target: S_IDLE};
      S_DISP_N:  cw = '{op: OP_NOP,         cond: C_REQ_NODE,   target: S_ADDN};
      S_DISP_E:  cw = '{op: OP_NOP,         cond: C_REQ_EDGE,   target: S_EDGE_RD};
      S_DISP_C:  cw = '{op: OP_NOP,         cond: C_REQ_CLEAR,  target: S_CLR};
      S_WALK:    cw = '{op: OP_WALK_INIT,   cond: C_START_BAD,  target: S_MISS};
      S_VISIT:   cw = '{op: OP_VISIT_START, cond: C_NEXT,       target: S_IDLE};
      S_LOAD:    cw = '{op: OP_LOAD_ROW,    cond: C_NEXT,       target: S_IDLE};
      S_SCAN:    cw = '{op: OP_SCAN,        cond: C_SCAN_MORE,  target: S_SCAN};
      S_TEST:    cw = '{op: OP_NOP,         cond: C_HIT,        target: S_PUSH};
      S_POP:     cw = '{op: OP_POP,         cond: C_LAST_FRAME, target: S_FINISH};
      S_POPLD:   cw = '{op: OP_POP_LOAD,    cond: C_ALWAYS,     target: S_LOAD};
      S_PUSH:    cw = '{op: OP_PUSH,        cond: C_ALWAYS,     target: S_LOAD};
      S_FINISH:  cw = '{op: OP_EMIT_LAST,   cond: C_ALWAYS,     target: S_IDLE};
      S_MISS:    cw = '{op: OP_EMIT_MISS,   cond: C_ALWAYS,     target: S_IDLE};
      S_ADDN:    cw = '{op: OP_SET_PRESENT, cond: C_ALWAYS,     target: S_IDLE};
      S_EDGE_RD: cw = '{op: OP_EDGE_READ,   cond: C_NEXT,       target: S_IDLE};
      S_EDGE_WR: cw = '{op: OP_EDGE_WRITE,  cond: C_ALWAYS,     target: S_IDLE};
      S_CLR:     cw = '{op: OP_CLEAR,       cond: C_ALWAYS,     target: S_IDLE};
      default:   cw = '{op: OP_NOP,         cond: C_ALWAYS,     target: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

### rtl/dfw_useq.sv
// ---------------------------------------------------------------------------
// dfw_useq
// Step counter and control store; picks the next step from the jump flags.
// ---------------------------------------------------------------------------
module dfw_useq
  import dfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dfw_flags_t flags,
  output dfw_ctrl_t  ctrl,
  output logic       busy
);

  step_t step_r;
  step_t step_nxt;
  logic  take;

  assign ctrl = ucode_rom(step_r);
  assign busy = (step_r != S_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NOT_START:  take = !start;
      C_REQ_NODE:   take = flags.req_node;
      C_REQ_EDGE:   take = flags.req_edge;
      C_REQ_CLEAR:  take = flags.req_clear;
      C_START_BAD:  take = flags.start_bad;
      C_SCAN_MORE:  take = flags.scan_more;
      C_HIT:        take = flags.hit;
      C_LAST_FRAME: take = flags.last_frame;
      default:      take = 1'b0;
    endcase
    step_nxt = take ? ctrl.target : step_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### rtl/dfw_dpath.sv
// ---------------------------------------------------------------------------
// dfw_dpath
// Graph store, walk stack, scan registers and result register, driven by
// one control word per cycle.
// ---------------------------------------------------------------------------
module dfw_dpath
  import dfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  dfw_in_t    in_item,
  input  dfw_ctrl_t  ctrl,
  output dfw_flags_t flags,
  output logic       out_valid,
  output dfw_out_t   out_item
);

  // adjacency rows, one valid bit per row stands in for the cleared value
  logic [NODE_CNT-1:0] adj_mem [NODE_CNT];
  logic [NODE_CNT-1:0] row_valid_r;
  logic [NODE_CNT-1:0] adj_q_r;
  logic                adj_vq_r;
  logic [NODE_W-1:0]   adj_raddr;
  logic [NODE_CNT-1:0] adj_old;
  logic [NODE_CNT-1:0] adj_wdata;

  // saved frames below the top one
  dfw_frame_t          stk_mem [NODE_CNT];
  dfw_frame_t          stk_q_r;
  logic [NODE_W-1:0]   stk_waddr;
  logic [NODE_W-1:0]   stk_raddr;

  dfw_in_t             req_r;
  logic [NODE_CNT-1:0] present_r;
  logic [NODE_CNT-1:0] visited_r;
  logic [NODE_CNT-1:0] row_r;
  logic [NODE_W-1:0]   cur_r;
  logic [CAND_W-1:0]   cand_r;
  logic [CAND_W-1:0]   depth_r;
  logic [NODE_W-1:0]   pend_r;
  logic                out_valid_r;
  dfw_out_t            out_item_r;

  logic [NODE_W-1:0]   cand_idx;
  logic                hit;

  assign cand_idx = cand_r[NODE_W-1:0];
  assign hit = !cand_r[CAND_W-1] && present_r[cand_idx] && row_r[cand_idx]
               && !visited_r[cand_idx];

  always_comb begin
    flags.req_node   = (req_r.req_type == REQ_ADD_NODE);
    flags.req_edge   = (req_r.req_type == REQ_ADD_EDGE);
    flags.req_clear  = (req_r.req_type == REQ_CLEAR);
    flags.start_bad  = !present_r[req_r.node_id];
    flags.hit        = hit;
    flags.scan_more  = !hit && (cand_r < CAND_W'(NODE_CNT - 1));
    flags.last_frame = (depth_r == CAND_W'(1));
  end

  always_comb begin
    unique case (ctrl.op)
      OP_PUSH:     adj_raddr = cand_idx;
      OP_POP_LOAD: adj_raddr = stk_q_r.node;
      default:     adj_raddr = req_r.node_id;
    endcase
    adj_old   = adj_vq_r ? adj_q_r : '0;
    adj_wdata = adj_old;
    adj_wdata[req_r.neighbor_id] = 1'b1;
    stk_waddr = depth_r[NODE_W-1:0] - NODE_W'(1);
    stk_raddr = depth_r[NODE_W-1:0] - NODE_W'(2);
  end

  // memories
  always_ff @(posedge clk) begin
    adj_q_r  <= adj_mem[adj_raddr];
    adj_vq_r <= row_valid_r[adj_raddr];
    if (ctrl.op == OP_EDGE_WRITE) begin
      adj_mem[req_r.node_id] <= adj_wdata;
    end
    stk_q_r <= stk_mem[stk_raddr];
    if (ctrl.op == OP_PUSH) begin
      stk_mem[stk_waddr] <= '{node: cur_r, next: cand_r + CAND_W'(1)};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_item;
    end
    unique case (ctrl.op)
      OP_VISIT_START: begin
        pend_r <= req_r.node_id;
        cur_r  <= req_r.node_id;
        cand_r <= '0;
      end
      OP_LOAD_ROW: begin
        row_r <= adj_vq_r ? adj_q_r : '0;
      end
      OP_SCAN: begin
        if (!hit) begin
          cand_r <= cand_r + CAND_W'(1);
        end
      end
      OP_POP_LOAD: begin
        cur_r  <= stk_q_r.node;
        cand_r <= stk_q_r.next;
      end
      OP_PUSH: begin
        pend_r <= cand_idx;
        cur_r  <= cand_idx;
        cand_r <= '0;
      end
      default: begin
      end
    endcase
    unique case (ctrl.op)
      OP_PUSH:      out_item_r <= '{visited_node: pend_r, is_last: 1'b0,
                                    start_missing: 1'b0};
      OP_EMIT_LAST: out_item_r <= '{visited_node: pend_r, is_last: 1'b1,
                                    start_missing: 1'b0};
      OP_EMIT_MISS: out_item_r <= '{visited_node: '0, is_last: 1'b1,
                                    start_missing: 1'b1};
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      visited_r   <= '0;
      row_valid_r <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctrl.op == OP_PUSH) || (ctrl.op == OP_EMIT_LAST)
                     || (ctrl.op == OP_EMIT_MISS);
      unique case (ctrl.op)
        OP_WALK_INIT: begin
          visited_r <= '0;
          depth_r   <= '0;
        end
        OP_VISIT_START: begin
          visited_r[req_r.node_id] <= 1'b1;
          depth_r                  <= CAND_W'(1);
        end
        OP_POP: begin
          depth_r <= depth_r - CAND_W'(1);
        end
        OP_PUSH: begin
          visited_r[cand_idx] <= 1'b1;
          depth_r             <= depth_r + CAND_W'(1);
        end
        OP_SET_PRESENT: begin
          present_r[req_r.node_id] <= 1'b1;
        end
        OP_EDGE_WRITE: begin
          row_valid_r[req_r.node_id] <= 1'b1;
        end
        OP_CLEAR: begin
          present_r   <= '0;
          visited_r   <= '0;
          row_valid_r <= '0;
          depth_r     <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // results never come in adjacent cycles in this program
  a_no_adjacent_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("dfw: results in adjacent cycles");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CAND_W'(NODE_CNT))
    else $error("dfw: stack depth beyond node count");

  // a push must follow a real, unvisited successor
  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_PUSH) |-> (hit && depth_r < CAND_W'(NODE_CNT)))
    else $error("dfw: push without a valid successor");

  a_clear_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_CLEAR) |=> (row_valid_r == '0 && present_r == '0))
    else $error("dfw: clear left graph state behind");
`endif

endmodule

### rtl/graph_depth_first_walk_top.sv
// ---------------------------------------------------------------------------
// graph_depth_first_walk_top
// Graph store with preorder depth-first walk, run by a microcoded sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   An item (req_type, node_id, neighbor_id) is taken on a rising edge with
//   start high and busy low. Add node, add edge and clear give no result;
//   a walk gives one result per visited node in visit order, the final one
//   with is_last set, or a single start_missing result if the start node is
//   absent. Each result sits on out_item for one cycle with out_valid high;
//   the receiver cannot stall, so nothing holds the block back.
//   Steps per item (busy after the accept edge): add node dispatches, then
//   sets the present bit; add edge reads the row and writes it back; clear
//   empties the graph; a missing-start walk emits the miss result. A walk
//   pushes, loads the row and tests per visited node, scans candidates and
//   pops frames; the candidate scan over each frame's adjacency row dominates.
//   The last result appears in the same cycle as busy drops.
//   Reset (rst_n low, synchronous) empties the graph: no nodes, no edges,
//   all row valid bits and visited marks cleared together, no pass.
// ---------------------------------------------------------------------------
module graph_depth_first_walk_top
  import dfw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dfw_in_t  in_item,
  output logic     out_valid,
  output dfw_out_t out_item
);

  dfw_ctrl_t  ctrl;
  dfw_flags_t flags;
  logic       in_acc;

  assign in_acc = start && !busy;

  dfw_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  dfw_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_item   (in_item),
    .ctrl      (ctrl),
    .flags     (flags),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
